// File: rtl/core/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared constants, command codes and transaction types of the bootloader
// command parser.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int PAGES_W    = 20;
    localparam int PAGE_W     = $clog2(PAGE_BYTES + 1);
    localparam int BOUND_W    = PAGES_W + PAGE_W;
    localparam int CMP_W      = (BOUND_W > ADDR_W) ? BOUND_W : ADDR_W;
    localparam int SLOTS      = 3;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam logic [7:0] BYTE_SET_BASE  = 8'h19;
    localparam logic [7:0] BYTE_PACKET    = 8'h29;
    localparam logic [7:0] BYTE_ERASE     = 8'h39;
    localparam logic [7:0] BYTE_RESET     = 8'h58;
    localparam logic [7:0] BYTE_JUMP      = 8'h59;

    localparam logic [2:0] CMD_ERASE = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_DONE  = 3'd2;
    localparam logic [2:0] CMD_RESET = 3'd3;
    localparam logic [2:0] CMD_JUMP  = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flash_ready;
    } t_in;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] target_address;
        logic [7:0]        write_data;
        logic              last_of_run;
    } t_out;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] target_address;
        logic [7:0]        write_data;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        t_cmd [SLOTS-1:0]   slot;
    } t_bundle;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             can_load;
    } t_seq_status;

endpackage

// File: rtl/core/bcp_parser.sv
// ----------------------------------------------------------------------------
// bcp_parser
// Parse state registers and the single-pass decode that turns one received
// byte into a bundle of up to three commands.
// ----------------------------------------------------------------------------
module bcp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  bcp_pkg::t_in    i_in,
    output bcp_pkg::t_bundle o_bundle
);
    import bcp_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_BASE_ADDR  = 3'd1;
    localparam logic [2:0] PH_SIZE_SKIP  = 3'd2;
    localparam logic [2:0] PH_LENGTH     = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_ERASE_ADDR = 3'd5;

    logic [2:0]         r_phase,  n_phase;
    logic [1:0]         r_fcount, n_fcount;
    logic [ADDR_W-1:0]  r_shift,  n_shift;
    logic [ADDR_W-1:0]  r_base,   n_base;
    logic [ADDR_W-1:0]  r_offset, n_offset;
    logic [PAGES_W-1:0] r_pages,  n_pages;
    logic [7:0]         r_remain, n_remain;

    logic [BOUND_W-1:0] w_boundary;
    logic               w_hit;
    logic [7:0]         w_remain_dec;
    logic               w_erase, w_write, w_done;
    t_cmd               w_erase_cmd, w_write_cmd, w_done_cmd;
    t_bundle            w_bundle;

    assign w_boundary   = BOUND_W'(PAGE_BYTES) * BOUND_W'(r_pages);
    assign w_hit        = (CMP_W'(r_offset) == CMP_W'(w_boundary));
    assign w_remain_dec = r_remain - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_fcount = r_fcount;
        n_shift  = r_shift;
        n_base   = r_base;
        n_offset = r_offset;
        n_pages  = r_pages;
        n_remain = r_remain;
        w_erase  = 1'b0;
        w_write  = 1'b0;
        w_done   = 1'b0;
        w_erase_cmd = '{command: CMD_ERASE,
                        target_address: r_base + ADDR_W'(w_boundary), write_data: 8'd0};
        w_write_cmd = '{command: CMD_WRITE,
                        target_address: r_base + r_offset, write_data: i_in.rx_byte};
        w_done_cmd  = '{command: CMD_DONE, target_address: '0, write_data: 8'd0};
        w_bundle = '0;

        case (r_phase)
            PH_IDLE: begin
                n_fcount = 2'd0;
                case (i_in.rx_byte)
                    BYTE_SET_BASE: n_phase = PH_BASE_ADDR;
                    BYTE_PACKET:   n_phase = PH_LENGTH;
                    BYTE_ERASE:    n_phase = PH_ERASE_ADDR;
                    BYTE_RESET: begin
                        w_bundle.count = CNT_W'(1);
                        w_bundle.slot[0].command = CMD_RESET;
                    end
                    BYTE_JUMP: begin
                        w_bundle.count = CNT_W'(1);
                        w_bundle.slot[0].command = CMD_JUMP;
                    end
                    default: ;
                endcase
            end
            PH_BASE_ADDR, PH_ERASE_ADDR: begin
                n_shift  = {r_shift[ADDR_W-9:0], i_in.rx_byte};
                n_fcount = r_fcount + 2'd1;
                if (r_fcount == 2'd3) begin
                    n_fcount = 2'd0;
                    n_base   = n_shift;
                    if (r_phase == PH_ERASE_ADDR) begin
                        n_phase = PH_IDLE;
                        w_bundle.count = CNT_W'(1);
                        w_bundle.slot[0] = '{command: CMD_ERASE, target_address: n_shift,
                                             write_data: 8'd0};
                    end else begin
                        n_phase = PH_SIZE_SKIP;
                    end
                end
            end
            PH_SIZE_SKIP: begin
                n_fcount = r_fcount + 2'd1;
                if (r_fcount == 2'd3) begin
                    n_fcount = 2'd0;
                    n_phase  = PH_IDLE;
                end
            end
            PH_LENGTH: begin
                n_remain = i_in.rx_byte;
                if (i_in.rx_byte == 8'd0) begin
                    n_phase = PH_IDLE;
                    w_bundle.count = CNT_W'(1);
                    w_bundle.slot[0] = w_done_cmd;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                w_erase  = w_hit;
                w_write  = i_in.flash_ready;
                w_done   = (w_remain_dec == 8'd0);
                if (w_hit) begin
                    n_pages = r_pages + PAGES_W'(1);
                end
                n_offset = r_offset + ADDR_W'(1);
                n_remain = w_remain_dec;
                if (w_done) begin
                    n_phase = PH_IDLE;
                end
                w_bundle.count = CNT_W'(w_erase) + CNT_W'(w_write) + CNT_W'(w_done);
                w_bundle.slot[0] = w_erase ? w_erase_cmd : (w_write ? w_write_cmd : w_done_cmd);
                w_bundle.slot[1] = (w_erase && w_write) ? w_write_cmd : w_done_cmd;
                w_bundle.slot[2] = w_done_cmd;
            end
            default: begin
                n_phase  = PH_IDLE;
                n_fcount = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fcount <= 2'd0;
            r_shift  <= '0;
            r_base   <= '0;
            r_offset <= '0;
            r_pages  <= '0;
            r_remain <= 8'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fcount <= n_fcount;
            r_shift  <= n_shift;
            r_base   <= n_base;
            r_offset <= n_offset;
            r_pages  <= n_pages;
            r_remain <= n_remain;
        end
    end

    assign o_bundle = w_bundle;

endmodule

// File: rtl/core/bcp_out_seq.sv
// ----------------------------------------------------------------------------
// bcp_out_seq
// Result register holding one command bundle and handing its commands out
// one transaction at a time.
// ----------------------------------------------------------------------------
module bcp_out_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bcp_pkg::t_bundle    i_bundle,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output bcp_pkg::t_out       o_out,
    output bcp_pkg::t_seq_status o_status
);
    import bcp_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd [SLOTS-1:0] r_slot, n_slot;
    logic             w_pop;

    assign w_pop = (r_cnt != '0) && i_out_ready;

    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        if (i_accept && (i_bundle.count != '0)) begin
            n_cnt  = i_bundle.count;
            n_slot = i_bundle.slot;
        end else if (w_pop) begin
            n_cnt  = r_cnt - CNT_W'(1);
            for (int k = 0; k < SLOTS - 1; k++) begin
                n_slot[k] = r_slot[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_out_valid          = (r_cnt != '0);
    assign o_out.command        = r_slot[0].command;
    assign o_out.target_address = r_slot[0].target_address;
    assign o_out.write_data     = r_slot[0].write_data;
    assign o_out.last_of_run    = (r_cnt == CNT_W'(1));

    assign o_status.count    = r_cnt;
    assign o_status.can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

endmodule

// File: rtl/core/bootloader_command_parser.sv
// ----------------------------------------------------------------------------
// bootloader_command_parser
// Parses the bootloader byte stream into erase, write, packet-done, reset
// and jump commands.
// ----------------------------------------------------------------------------
// The first command of a byte is registered and appears in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one command and
// the output is ready; a byte with more commands holds the input while the
// single result register drains one command per cycle with the output ready.
// Reset: synchronous; the parser returns to idle and all counters clear.
// ----------------------------------------------------------------------------
module bootloader_command_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bcp_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bcp_pkg::t_out  o_out
);
    import bcp_pkg::*;

    logic        w_accept;
    t_bundle     w_bundle;
    t_seq_status w_status;

    assign o_in_ready = w_status.can_load;
    assign w_accept   = i_in_valid && w_status.can_load;

    bcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in),
        .o_bundle (w_bundle)
    );

    bcp_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_bundle    (w_bundle),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_status    (w_status)
    );

    a_no_accept_while_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.count > CNT_W'(1)) |-> !o_in_ready)
        else $error("input taken while several commands are pending");

    a_command_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.command <= CMD_JUMP))
        else $error("command code out of range");

    a_data_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.command != CMD_WRITE)) |-> (o_out.write_data == 8'd0))
        else $error("write data on a non-write command");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// File: tb/sv/tb_bootloader_command_parser.sv
// ----------------------------------------------------------------------------
// tb_bootloader_command_parser
// Self-checking testbench of the bootloader command parser. A directed table
// covers the command bytes, the extremes of the byte and address fields, a
// zero-length packet and a dropped write. Random command sequences follow.
// Every accepted input transaction is run through a behavioral predictor,
// and each output transaction is compared field by field with the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bootloader_command_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import bcp_pkg::*;

    localparam int RANDOM_ITEMS = 170;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 120;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_BASE,
        PARSE_SIZE,
        PARSE_LENGTH,
        PARSE_DATA,
        PARSE_ERASE
    } t_parse;

    typedef struct packed {
        t_in  item;
        logic known;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    t_parse      parse_state = PARSE_IDLE;
    logic [2:0]  field_cnt   = '0;
    logic [31:0] addr_acc    = '0;
    logic [31:0] base_addr   = '0;
    logic [31:0] wr_offset   = '0;
    logic [19:0] pages_done  = '0;
    logic [7:0]  data_left   = '0;

    t_out step_cmds[$];
    t_out expected_cmds[$];
    t_row directed_rows[$];

    int fail_count    = 0;
    int counted_items = 0;
    int burst_left    = 0;
    bit long_hold_req = 1'b0;

    bootloader_command_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void queue_cmd(input logic [2:0] cmd, input logic [31:0] addr,
                                      input logic [7:0] data);
        t_out c;
        c.command        = cmd;
        c.target_address = addr;
        c.write_data     = data;
        c.last_of_run    = 1'b0;
        step_cmds.push_back(c);
    endfunction

    function automatic logic shift_in_address(input logic [7:0] b);
        addr_acc  = {addr_acc[23:0], b};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt >= 3'd4) begin
            field_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the parser state by one byte and leaves the commands it causes
    // in step_cmds. Returns zero for a byte that the idle parser ignores.
    function automatic logic predict_byte(input t_in item);
        logic [7:0]  b;
        logic [63:0] boundary;
        logic        taken;
        b     = item.rx_byte;
        taken = 1'b1;
        step_cmds.delete();
        case (parse_state)
            PARSE_IDLE: begin
                field_cnt = '0;
                if (b == BYTE_SET_BASE) parse_state = PARSE_BASE;
                else if (b == BYTE_PACKET) parse_state = PARSE_LENGTH;
                else if (b == BYTE_ERASE) parse_state = PARSE_ERASE;
                else if (b == BYTE_RESET) queue_cmd(CMD_RESET, '0, '0);
                else if (b == BYTE_JUMP) queue_cmd(CMD_JUMP, '0, '0);
                else taken = 1'b0;
            end
            PARSE_BASE: begin
                if (shift_in_address(b)) begin
                    base_addr   = addr_acc;
                    parse_state = PARSE_SIZE;
                end
            end
            PARSE_SIZE: begin
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= 3'd4) begin
                    field_cnt   = '0;
                    parse_state = PARSE_IDLE;
                end
            end
            PARSE_LENGTH: begin
                data_left = b;
                if (b == 8'd0) begin
                    queue_cmd(CMD_DONE, '0, '0);
                    parse_state = PARSE_IDLE;
                end else begin
                    parse_state = PARSE_DATA;
                end
            end
            PARSE_DATA: begin
                boundary = 64'(PAGE_BYTES) * 64'(pages_done);
                if ({32'd0, wr_offset} == boundary) begin
                    queue_cmd(CMD_ERASE, base_addr + boundary[31:0], '0);
                    pages_done = pages_done + 20'd1;
                end
                if (item.flash_ready) queue_cmd(CMD_WRITE, base_addr + wr_offset, b);
                wr_offset = wr_offset + 32'd1;
                data_left = data_left - 8'd1;
                if (data_left == 8'd0) begin
                    queue_cmd(CMD_DONE, '0, '0);
                    parse_state = PARSE_IDLE;
                end
            end
            PARSE_ERASE: begin
                if (shift_in_address(b)) begin
                    base_addr = addr_acc;
                    queue_cmd(CMD_ERASE, base_addr, '0);
                    parse_state = PARSE_IDLE;
                end
            end
            default: begin
                parse_state = PARSE_IDLE;
                field_cnt   = '0;
            end
        endcase
        if (step_cmds.size() != 0) step_cmds[step_cmds.size() - 1].last_of_run = 1'b1;
        return taken;
    endfunction

    function automatic t_in mk_byte(input logic [7:0] b, input logic rdy);
        t_in t;
        t.rx_byte     = b;
        t.flash_ready = rdy;
        return t;
    endfunction

    function automatic t_row dir_row(input logic [7:0] b, input logic rdy, input logic known,
                                     input logic [2:0] cmd, input logic [31:0] addr);
        t_row r;
        r.item                = mk_byte(b, rdy);
        r.known               = known;
        r.want.command        = cmd;
        r.want.target_address = addr;
        r.want.write_data     = '0;
        r.want.last_of_run    = 1'b1;
        return r;
    endfunction

    function automatic logic rnd_ready();
        return $urandom_range(0, 4) != 0;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Offers one input transaction and waits for it to be taken. Between bursts
    // the sender drops valid for a random pause.
    task automatic send_byte(input t_in item, input logic known, input t_out want);
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_byte(item)) counted_items++;
        if (known) expected_cmds.push_back(want);
        else foreach (step_cmds[k]) expected_cmds.push_back(step_cmds[k]);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(mk_byte(b, rnd_ready()), 1'b0, '0);
    endtask

    task automatic send_address(input logic [31:0] a);
        for (int k = 3; k >= 0; k--) send_plain(a[8*k +: 8]);
    endtask

    task automatic send_packet(input int len);
        send_plain(BYTE_PACKET);
        send_plain(8'(len));
        repeat (len) send_plain(8'($urandom_range(0, 255)));
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_sequence();
        int          kind;
        int          len;
        logic [31:0] a;
        kind = $urandom_range(0, 99);
        a    = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 8))
                                           : 32'($urandom());
        if (kind < 45) begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = $urandom_range(9, 40);
                default: len = $urandom_range(1, 8);
            endcase
            send_packet(len);
        end else if (kind < 58) begin
            send_plain(BYTE_SET_BASE);
            send_address(a);
            send_address(32'($urandom()));
        end else if (kind < 70) begin
            send_plain(BYTE_ERASE);
            send_address(a);
        end else if (kind < 76) begin
            send_plain(BYTE_RESET);
        end else if (kind < 82) begin
            send_plain(BYTE_JUMP);
        end else if (kind < 92) begin
            send_plain(8'($urandom_range(0, 255)));
        end else begin
            // A command cut short: the bytes that follow fill its fields.
            case ($urandom_range(0, 2))
                0: send_plain(BYTE_SET_BASE);
                1: send_plain(BYTE_ERASE);
                default: send_plain(BYTE_PACKET);
            endcase
            repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 40);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t ns: unexpected transaction, expected none, actual 0x%0h",
                         $time, o_out);
                fail_count++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("command", 32'(want.command), 32'(o_out.command));
                check_field("target_address", want.target_address, o_out.target_address);
                check_field("write_data", 32'(want.write_data), 32'(o_out.write_data));
                check_field("last_of_run", 32'(want.last_of_run), 32'(o_out.last_of_run));
            end
        end
    end

    initial begin
        bit mid_pause_done;
        mid_pause_done = 1'b0;

        directed_rows.push_back(dir_row(BYTE_RESET, 1'b0, 1'b1, CMD_RESET, '0));
        directed_rows.push_back(dir_row(BYTE_JUMP, 1'b1, 1'b1, CMD_JUMP, '0));
        directed_rows.push_back(dir_row(8'h00, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'hFF, 1'b0, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_PACKET, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, CMD_DONE, '0));
        directed_rows.push_back(dir_row(BYTE_ERASE, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'hFF, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'hFF, 1'b0, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'hF0, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, CMD_ERASE, 32'hFFFF_F000));
        directed_rows.push_back(dir_row(BYTE_SET_BASE, 1'b1, 1'b0, CMD_ERASE, '0));
        repeat (4) directed_rows.push_back(dir_row(8'hFF, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_RESET, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_JUMP, 1'b0, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_ERASE, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_PACKET, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(BYTE_PACKET, 1'b0, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'h02, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'hFF, 1'b1, 1'b0, CMD_ERASE, '0));
        directed_rows.push_back(dir_row(8'h00, 1'b0, 1'b0, CMD_ERASE, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
        end
        pause_until_drained();

        counted_items = 0;
        long_hold_req = 1'b1;
        while (counted_items < RANDOM_ITEMS) begin
            send_random_sequence();
            if (!mid_pause_done && counted_items >= RANDOM_ITEMS / 2) begin
                pause_until_drained();
                mid_pause_done = 1'b1;
            end
        end

        pause_until_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
